// ===== rtl/core/smcs_pkg.sv =====
package smcs_pkg;

  typedef enum logic [1:0] {
    CMD_WRITE  = 2'd0,
    CMD_NORM   = 2'd1,
    CMD_SAMPLE = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MAX,
    ST_EXP,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_EMIT,
    ST_SAMP,
    ST_SAMP_EMIT
  } state_e;

  localparam int unsigned WeightW = 17;
  localparam int unsigned LogitW  = 16;
  localparam int unsigned ExpW    = 17;
  localparam int unsigned SumW    = 21;

  // 2^(-f/256) in Q1.16 for f = 0..255.
  function automatic logic [16:0] frac_rom(input logic [7:0] f);
    logic [63:0] a;
    logic [63:0] c [8];
    c[0] = 64'd3037000500; c[1] = 64'd3611622603;
    c[2] = 64'd3938502376; c[3] = 64'd4112874773;
    c[4] = 64'd4202935622; c[5] = 64'd4248701965;
    c[6] = 64'd4271771996; c[7] = 64'd4283353945;
    a = 64'd1 << 32;
    for (int k = 0; k < 8; k++) begin
      if (f[7-k]) begin
        a = (a * c[k] + (64'd1 << 31)) >> 32;
      end
    end
    a = (a + 64'd32768) >> 16;
    return a[16:0];
  endfunction

endpackage

// ===== rtl/core/softmax_categorical_sampler.sv =====
// Channel | Direction | Signals
// input   | in        | in_valid_i, in_stall_o, cmd_i, entry_index_i, logit_value_i, draw_i
// output  | out       | out_valid_o, out_stall_i, weight_o, component_o, is_last_o
// config  | in        | cfg_we_i, cfg_wdata_i
//
// A normalization runs over the N active entries through the serial divider
// (one quotient bit per cycle) that is shared by all entries. A sample scans
// the cumulative weights of up to N entries.
// Reset sets all logits to zero, all weights to 4096 and the count to 16.
// A stalled result holds the sequencer; no new transaction is taken until
// the last result of the current one has left.
module softmax_categorical_sampler import smcs_pkg::*; #(
  parameter int unsigned MAX_COMPONENTS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [4:0]               cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               cmd_i,
  input  logic [3:0]               entry_index_i,
  input  logic signed [LogitW-1:0] logit_value_i,
  input  logic [15:0]              draw_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic [WeightW-1:0]       weight_o,
  output logic [3:0]               component_o,
  output logic                     is_last_o
);
  localparam int unsigned Lim = (MAX_COMPONENTS < 16) ? MAX_COMPONENTS : 16;
  localparam int unsigned IW  = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;

  // Stores with valid bits; an entry not yet written reads its reset value.
  logic signed [LogitW-1:0] logit_mem [MAX_COMPONENTS];
  logic [WeightW-1:0]       wt_mem    [MAX_COMPONENTS];
  logic [ExpW-1:0]          e_mem     [16];
  logic [MAX_COMPONENTS-1:0] lv_q, wv_q;

  // Fraction table 2^(-f/256), fixed at elaboration.
  logic [16:0] frac_tab [256];

  state_e state_q, state_d;
  logic [4:0]  cnt_q, cnt_d, nact_q;
  logic [4:0]  n;
  logic signed [LogitW-1:0] max_q, max_d;
  logic [SumW-1:0] sum_q, sum_d;
  logic [16:0] cum_q, cum_d;
  logic [15:0] draw_q;
  logic [3:0]  k;
  logic        accept, fire;
  logic signed [LogitW-1:0] lg;
  logic [WeightW-1:0] wt;
  logic [16:0] dd;
  logic [25:0] xx;
  logic [ExpW-1:0] ev;
  logic [17:0] cum_n;
  logic        dstart, dbusy;
  logic [WeightW-1:0] quot;
  logic        ov_q;
  logic [WeightW-1:0] ow_q;
  logic [3:0]  oc_q;
  logic        ol_q;

  for (genvar g = 0; g < 256; g++) begin : g_frac_tab
    assign frac_tab[g] = frac_rom(8'(g));
  end

  always_comb begin
    n = (nact_q == 5'd0) ? 5'd1 : nact_q;
    if (n > 5'(Lim)) n = 5'(Lim);
  end

  assign k   = cnt_q[3:0];
  assign lg  = (32'(cnt_q) < MAX_COMPONENTS && lv_q[IW'(k)]) ? logit_mem[IW'(k)] : '0;
  assign wt  = (32'(cnt_q) < MAX_COMPONENTS && wv_q[IW'(k)]) ? wt_mem[IW'(k)]
                                                           : WeightW'(4096);
  // The distance to the maximum is 0..65535, so the low 16 bits carry it exactly.
  assign dd    = {1'b0, 16'(max_q - lg)};
  assign xx    = 26'(dd) * 26'd369;
  assign ev    = (xx[25:16] >= 10'd17) ? '0 : (frac_tab[xx[15:8]] >> xx[20:16]);
  assign cum_n = {1'b0, cum_q} + {1'b0, wt};

  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE) || ov_q;
  assign fire = ov_q && !out_stall_i;

  smcs_div u_div (
    .clk_i, .rst_ni,
    .start_i(dstart), .num_i(e_mem[k]), .den_i(sum_q),
    .busy_o(dbusy), .quot_o(quot)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept) begin
        case (cmd_i)
          CMD_NORM:   state_d = ST_MAX;
          CMD_SAMPLE: state_d = ST_SAMP;
          default:    state_d = ST_IDLE;
        endcase
      end
      ST_MAX:       if (cnt_q == n - 5'd1) state_d = ST_EXP;
      ST_EXP:       if (cnt_q == n - 5'd1) state_d = ST_DIV_START;
      ST_DIV_START: state_d = ST_DIV_WAIT;
      ST_DIV_WAIT:  if (!dbusy && !ov_q) state_d = ST_EMIT;
      ST_EMIT:      state_d = (cnt_q == n - 5'd1) ? ST_IDLE : ST_DIV_START;
      ST_SAMP:      if (({1'b0, draw_q} <= cum_n) || cnt_q == n - 5'd1)
                      state_d = ST_SAMP_EMIT;
      ST_SAMP_EMIT: if (!ov_q) state_d = ST_IDLE;
      default:      state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_d  = cnt_q;
    max_d  = max_q;
    sum_d  = sum_q;
    cum_d  = cum_q;
    dstart = 1'b0;
    case (state_q)
      ST_IDLE: begin
        cnt_d = '0;
        cum_d = '0;
        max_d = (lv_q[0]) ? logit_mem[0] : '0;
        sum_d = '0;
      end
      ST_MAX: begin
        if (lg > max_q) max_d = lg;
        cnt_d = (cnt_q == n - 5'd1) ? 5'd0 : cnt_q + 5'd1;
      end
      ST_EXP: begin
        sum_d = sum_q + SumW'(ev);
        cnt_d = (cnt_q == n - 5'd1) ? 5'd0 : cnt_q + 5'd1;
      end
      ST_DIV_START: dstart = 1'b1;
      ST_EMIT:      cnt_d = cnt_q + 5'd1;
      ST_SAMP: begin
        cum_d = cum_n[16:0];
        if (!(({1'b0, draw_q} <= cum_n) || cnt_q == n - 5'd1)) cnt_d = cnt_q + 5'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      nact_q  <= 5'd16;
      lv_q    <= '0;
      wv_q    <= '0;
      ov_q    <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i) nact_q <= cfg_wdata_i;
      if (accept && cmd_i == CMD_WRITE && 32'(entry_index_i) < MAX_COMPONENTS)
        lv_q[IW'(entry_index_i)] <= 1'b1;
      if (state_q == ST_DIV_WAIT && !dbusy && !ov_q) wv_q[IW'(k)] <= 1'b1;
      if (fire) ov_q <= 1'b0;
      else if ((state_q == ST_DIV_WAIT && !dbusy) || state_q == ST_SAMP_EMIT) ov_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    max_q <= max_d;
    sum_q <= sum_d;
    cum_q <= cum_d;
    if (accept) draw_q <= draw_i;
    if (accept && cmd_i == CMD_WRITE && 32'(entry_index_i) < MAX_COMPONENTS)
      logit_mem[IW'(entry_index_i)] <= logit_value_i;
    if (state_q == ST_EXP) e_mem[k] <= ev;
    if (state_q == ST_DIV_WAIT && !dbusy && !ov_q) begin
      wt_mem[IW'(k)] <= quot;
      ow_q <= quot;
      oc_q <= k;
      ol_q <= (cnt_q == n - 5'd1);
    end else if (state_q == ST_SAMP_EMIT && !ov_q) begin
      ow_q <= wt;
      oc_q <= k;
      ol_q <= 1'b1;
    end
  end

  assign out_valid_o = ov_q;
  assign weight_o    = ow_q;
  assign component_o = oc_q;
  assign is_last_o   = ol_q;

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !accept) else $error("accept while busy");
  a_div_only_norm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dbusy |-> (state_q == ST_DIV_WAIT || state_q == ST_DIV_START))
    else $error("divider busy outside normalization");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ov_q && out_stall_i) |=> (ov_q && $stable(ow_q))) else $error("result dropped");
endmodule

// ===== rtl/core/smcs_div.sv =====
// Restoring divider: quotient = (num << 16) / den, one bit per cycle.
module smcs_div import smcs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [ExpW-1:0]    num_i,
  input  logic [SumW-1:0]    den_i,
  output logic               busy_o,
  output logic [WeightW-1:0] quot_o
);
  localparam int unsigned DW = ExpW + 16;

  logic [DW-1:0]   dvd_q, dvd_d;
  logic [SumW-1:0] rem_q, rem_d;
  logic [SumW-1:0] den_q, den_d;
  logic [5:0]      cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic [SumW:0]   trial;
  logic [SumW:0]   diff;

  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q, dvd_q[DW-1]};
    diff   = trial - {1'b0, den_q};
    if (start_i) begin
      dvd_d  = {num_i, 16'd0};
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = 6'(DW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = diff[SumW-1:0];
        dvd_d = {dvd_q[DW-2:0], 1'b1};
      end else begin
        rem_d = trial[SumW-1:0];
        dvd_d = {dvd_q[DW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o = busy_q;
  assign quot_o = dvd_q[WeightW-1:0];
endmodule
